@@ rtl/core/rhc_pkg.sv @@
`timescale 1ns / 1ps

package rhc_pkg;

   // Field widths
   localparam int CHAN_W    = 8;
   localparam int HUE_W     = 15;
   localparam int DEN_W     = CHAN_W + 1;
   localparam int SECT_W    = CHAN_W + 3;
   localparam int HUE_NUM_W = 24;
   localparam int SAT_NUM_W = 17;

   // One full turn of hue in 1/64 degree
   localparam logic [HUE_W-1:0] HUE_FULL_TURN = HUE_W'(23040);

   // Hue sector chosen by the first maximum channel
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // Operands and partial results handed from cell to cell
   typedef struct packed {
      logic [HUE_NUM_W-1:0] hue_rem;
      logic [DEN_W-1:0]     hue_den;
      logic [HUE_W-1:0]     hue_quo;
      logic [SAT_NUM_W-1:0] sat_rem;
      logic [DEN_W-1:0]     sat_den;
      logic [CHAN_W-1:0]    sat_quo;
      logic [CHAN_W-1:0]    value;
   } div_data_type;

endpackage

@@ rtl/core/rhc_req_if.sv @@
`timescale 1ns / 1ps

interface rhc_req_if import rhc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/core/rhc_rsp_if.sv @@
`timescale 1ns / 1ps

interface rhc_rsp_if import rhc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [CHAN_W-1:0] saturation;
   logic [CHAN_W-1:0] value;

   modport source (output valid, output hue, output saturation, output value, input ready);
   modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

@@ rtl/core/rgb_to_hsv_convert_top.sv @@
`timescale 1ns / 1ps

// Channel    Port      Dir  Payload
// request    req_chan  in   red[7:0], green[7:0], blue[7:0]
// response   rsp_chan  out  hue[14:0] (1/64 deg), saturation[7:0], value[7:0]
//
// Throughput is one request per cycle while rsp_chan is ready. There is one
// prepare stage, then one cell per hue quotient bit (15), each cell also
// doing one saturation quotient bit in the last eight. Reset clears only the
// stage valid bits. Each stage holds while its successor is full and
// stalled, so bubbles close up and requests are taken while a response waits.

module rgb_to_hsv_convert_top import rhc_pkg::*; (
   input logic     clock,
   input logic     reset,
   rhc_req_if.sink   req_chan,
   rhc_rsp_if.source rsp_chan
);

   localparam int NUM_STAGES = HUE_W + 1;

   logic         stage_valid [NUM_STAGES];
   logic         stage_ready [NUM_STAGES];
   div_data_type stage_data  [NUM_STAGES];
   logic [HUE_W-1:0] hue_raw;

   // Prepare operands
   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .red       (req_chan.red),
      .green     (req_chan.green),
      .blue      (req_chan.blue),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   // Divider cells, most significant quotient bit first
   for (genvar k = 0; k < HUE_W; k++) begin : g_cell
      rhc_div_cell #(
         .STEP (HUE_W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // Wrap a rounded-up full turn back to zero
   assign hue_raw = stage_data[NUM_STAGES-1].hue_quo;
   assign rsp_chan.hue = (hue_raw >= HUE_FULL_TURN) ? (hue_raw - HUE_FULL_TURN) : hue_raw;
   assign rsp_chan.saturation = stage_data[NUM_STAGES-1].sat_quo;
   assign rsp_chan.value = stage_data[NUM_STAGES-1].value;
   assign rsp_chan.valid = stage_valid[NUM_STAGES-1];
   assign stage_ready[NUM_STAGES-1] = rsp_chan.ready;

`ifndef SYNTH
   // Hue stays inside one turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.hue < HUE_FULL_TURN))
      else $error("hue out of range");

   // Black pixel gives zero hue and saturation
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.value == '0)) |->
         ((rsp_chan.hue == '0) && (rsp_chan.saturation == '0)))
      else $error("black pixel with nonzero hue or saturation");

   // Zero saturation on a lit pixel means grey, so hue is zero
   a_grey: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.value != '0) && (rsp_chan.saturation == '0))
         |-> (rsp_chan.hue == '0))
      else $error("grey pixel with nonzero hue");
`endif

endmodule

@@ rtl/core/rhc_front.sv @@
`timescale 1ns / 1ps

module rhc_front import rhc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CHAN_W-1:0] red,
   input  logic [CHAN_W-1:0] green,
   input  logic [CHAN_W-1:0] blue,
   output logic              out_valid,
   input  logic              out_ready,
   output div_data_type      out_data
);

   // 7680 = 8192 - 512 and 510 = 512 - 2
   localparam int HUE_SH_HI = 13;
   localparam int HUE_SH_LO = 9;
   localparam int SAT_SH_HI = 9;
   localparam int SAT_SH_LO = 1;

   logic [CHAN_W-1:0]    mx;
   logic [CHAN_W-1:0]    mn;
   logic [CHAN_W-1:0]    chroma;
   sector_type           sector;
   logic [SECT_W-1:0]    c2;
   logic [SECT_W-1:0]    c4;
   logic [SECT_W-1:0]    c6;
   logic [SECT_W-1:0]    r_ext;
   logic [SECT_W-1:0]    g_ext;
   logic [SECT_W-1:0]    b_ext;
   logic [SECT_W-1:0]    sect_pos;
   logic [HUE_NUM_W-1:0] pos_ext;
   logic [SAT_NUM_W-1:0] chroma_ext;
   div_data_type         data_in;
   div_data_type         data_ff;
   logic                 valid_ff;

   // Find the largest and smallest channel
   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      chroma = mx - mn;
   end

   // Pick the sector, first maximum in red, green, blue order
   always_comb begin
      if (red == mx) begin
         sector = SECT_RED;
      end else if (green == mx) begin
         sector = SECT_GREEN;
      end else begin
         sector = SECT_BLUE;
      end
   end

   // Position within the full turn in units of chroma, 0 to 6*chroma
   always_comb begin
      r_ext = SECT_W'(red);
      g_ext = SECT_W'(green);
      b_ext = SECT_W'(blue);
      c2    = SECT_W'(chroma) << 1;
      c4    = SECT_W'(chroma) << 2;
      c6    = c4 + c2;
      case (sector)
         SECT_RED: begin
            if (green >= blue) sect_pos = g_ext - b_ext;
            else sect_pos = c6 - (b_ext - g_ext);
         end
         SECT_GREEN: sect_pos = c2 + b_ext - r_ext;
         SECT_BLUE:  sect_pos = c4 + r_ext - g_ext;
         default:    sect_pos = '0;
      endcase
   end

   // Build rounding dividends and divisors; force a zero divisor to one
   always_comb begin
      pos_ext    = HUE_NUM_W'(sect_pos);
      chroma_ext = SAT_NUM_W'(chroma);
      data_in.hue_rem = (pos_ext << HUE_SH_HI) - (pos_ext << HUE_SH_LO)
                        + HUE_NUM_W'(chroma);
      data_in.hue_den = (chroma == '0) ? DEN_W'(1) : {chroma, 1'b0};
      data_in.hue_quo = '0;
      data_in.sat_rem = (chroma_ext << SAT_SH_HI) - (chroma_ext << SAT_SH_LO)
                        + SAT_NUM_W'(mx);
      data_in.sat_den = (mx == '0) ? DEN_W'(1) : {mx, 1'b0};
      data_in.sat_quo = '0;
      data_in.value   = mx;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Advance the stage whenever it is empty or the next one takes the request
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ rtl/core/rhc_div_cell.sv @@
`timescale 1ns / 1ps

module rhc_div_cell import rhc_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_data_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output div_data_type out_data
);

   localparam logic [HUE_W-1:0]  HUE_BIT = HUE_W'(1) << STEP;
   localparam logic [CHAN_W-1:0] SAT_BIT = CHAN_W'(1) << STEP;

   logic [HUE_NUM_W-1:0] hue_sub;
   logic [SAT_NUM_W-1:0] sat_sub;
   div_data_type         data_in;
   div_data_type         data_ff;
   logic                 valid_ff;

   assign hue_sub = HUE_NUM_W'(in_data.hue_den) << STEP;
   assign sat_sub = SAT_NUM_W'(in_data.sat_den) << STEP;

   // One restoring step of each divider; saturation has only the low bits
   always_comb begin
      data_in = in_data;
      if (in_data.hue_rem >= hue_sub) begin
         data_in.hue_rem = in_data.hue_rem - hue_sub;
         data_in.hue_quo = in_data.hue_quo | HUE_BIT;
      end
      if ((STEP < CHAN_W) && (in_data.sat_rem >= sat_sub)) begin
         data_in.sat_rem = in_data.sat_rem - sat_sub;
         data_in.sat_quo = in_data.sat_quo | SAT_BIT;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Hold when the neighbor stalls, otherwise advance
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ dv/rgb_to_hsv_convert_top_tb.sv @@
`timescale 1ns / 1ps

module rgb_to_hsv_convert_top_tb;
   import rhc_pkg::*;

   localparam int HUE_SIXTH        = 60 * 64;
   localparam int FULL_TURN_UNITS  = int'(HUE_FULL_TURN);
   localparam int STALL_LIMIT      = 2000;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int DRAIN_SLACK      = 24;
   localparam int MAX_REPORTS      = 10;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] value;
   } hsv_pixel_type;

   typedef struct packed {
      rgb_pixel_type pixel;
      hsv_pixel_type hsv;
   } pending_hsv_type;

   logic clock = 1'b0;
   logic reset;

   rhc_req_if req_if ();
   rhc_rsp_if rsp_if ();

   rgb_to_hsv_convert_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   pending_hsv_type pending_hsv[$];
   int unsigned  pixels_sent      = 0;
   int unsigned  pixels_checked   = 0;
   int unsigned  mismatch_count   = 0;
   bit           req_gaps_on      = 1'b0;
   bit           rsp_gaps_on      = 1'b0;
   bit           hold_request     = 1'b0;

   always #6 clock = ~clock;

   // Compute hue, saturation and value for one pixel
   function automatic hsv_pixel_type predict_hsv(rgb_pixel_type px);
      int            top;
      int            bottom;
      int            chroma;
      int            num;
      int            quo;
      sector_type    sector;
      hsv_pixel_type res;
      res    = '0;
      top    = int'(px.red);
      bottom = int'(px.red);
      if (int'(px.green) > top) top = int'(px.green);
      if (int'(px.blue) > top) top = int'(px.blue);
      if (int'(px.green) < bottom) bottom = int'(px.green);
      if (int'(px.blue) < bottom) bottom = int'(px.blue);
      res.value = CHAN_W'(top);
      if (top != 0) begin
         chroma = top - bottom;
         res.saturation = CHAN_W'((2 * 255 * chroma + top) / (2 * top));
         if (chroma != 0) begin
            // first maximum in red, green, blue order picks the sector
            if (int'(px.red) == top) sector = SECT_RED;
            else if (int'(px.green) == top) sector = SECT_GREEN;
            else sector = SECT_BLUE;
            case (sector)
               SECT_RED: begin
                  num = HUE_SIXTH * (int'(px.green) - int'(px.blue));
               end
               SECT_GREEN: begin
                  num = 2 * HUE_SIXTH * chroma + HUE_SIXTH * (int'(px.blue) - int'(px.red));
               end
               default: begin
                  num = 4 * HUE_SIXTH * chroma + HUE_SIXTH * (int'(px.red) - int'(px.green));
               end
            endcase
            if (num < 0) num += FULL_TURN_UNITS * chroma;
            // round half up, then wrap a full turn to zero
            quo = (2 * num + chroma) / (2 * chroma);
            if (quo >= FULL_TURN_UNITS) quo -= FULL_TURN_UNITS;
            res.hue = HUE_W'(quo);
         end
      end
      return res;
   endfunction

   // Pick an idle length: mostly none, often short, rarely long
   function automatic int unsigned gap_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Draw a pixel, biased toward grey, tied, near-grey, full-or-zero channel and dark colors
   function automatic rgb_pixel_type random_pixel();
      rgb_pixel_type px;
      logic [7:0]    v;
      logic [7:0]    o;
      int unsigned   kind;
      kind = $urandom_range(0, 9);
      v    = 8'($urandom_range(0, 255));
      o    = 8'($urandom_range(0, 255));
      px   = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255))};
      case (kind)
         5: px = {v, v, v};
         6: begin
            case ($urandom_range(0, 2))
               0: px = {v, v, o};
               1: px = {v, o, v};
               default: px = {o, v, v};
            endcase
         end
         7: begin
            px.red   = (v > 3) ? v - 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 3));
            px.green = (v > 3) ? v - 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 3));
            px.blue  = (v > 3) ? v - 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 3));
         end
         8: begin
            case ($urandom_range(0, 2))
               0: px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               1: px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               default: px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
         end
         9: px = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                  8'($urandom_range(0, 3))};
         default: ;
      endcase
      return px;
   endfunction

   // Offer one request, hold it until taken, then queue its expected result
   task automatic send_pixel(input rgb_pixel_type px);
      int unsigned gap;
      req_if.valid <= 1'b1;
      req_if.red   <= px.red;
      req_if.green <= px.green;
      req_if.blue  <= px.blue;
      do @(posedge clock); while (!req_if.ready);
      pending_hsv.push_back('{pixel: px, hsv: predict_hsv(px)});
      pixels_sent++;
      gap = req_gaps_on ? gap_cycles() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid at the end of a burst
   task automatic release_request();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_hsv.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      rgb_pixel_type corners[$];
      corners = '{
         {8'd0,   8'd0,   8'd0},    // black
         {8'd255, 8'd255, 8'd255},  // white
         {8'd128, 8'd128, 8'd128},  // grey
         {8'd1,   8'd1,   8'd1},
         {8'd255, 8'd0,   8'd0},    // primaries
         {8'd0,   8'd255, 8'd0},
         {8'd0,   8'd0,   8'd255},
         {8'd255, 8'd255, 8'd0},    // ties in the maximum
         {8'd0,   8'd255, 8'd255},
         {8'd255, 8'd0,   8'd255},
         {8'd200, 8'd200, 8'd10},
         {8'd255, 8'd0,   8'd1},    // negative hue, just under a full turn
         {8'd255, 8'd254, 8'd255},
         {8'd2,   8'd1,   8'd1},    // saturation exactly on a half
         {8'd1,   8'd0,   8'd0},
         {8'd0,   8'd1,   8'd0},
         {8'd0,   8'd0,   8'd1},
         {8'd255, 8'd254, 8'd254},  // smallest chroma at full value
         {8'd254, 8'd255, 8'd253},
         {8'd170, 8'd85,  8'd0},
         {8'd85,  8'd170, 8'd255},
         {8'd128, 8'd64,  8'd191}
      };
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      foreach (corners[i]) send_pixel(corners[i]);
      release_request();
   endtask

   // Back-to-back stream with the output always ready
   task automatic test_random_stream();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      repeat (150) send_pixel(random_pixel());
      release_request();
   endtask

   // Random gaps on both sides
   task automatic test_random_gaps();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      repeat (300) send_pixel(random_pixel());
      release_request();
   endtask

   // Hold the output off for a long stretch while requests keep coming
   task automatic test_output_hold();
      req_gaps_on  = 1'b0;
      rsp_gaps_on  = 1'b0;
      hold_request = 1'b1;
      repeat (80) send_pixel(random_pixel());
      release_request();
   endtask

   // Pause the sender until every result is back, then resume
   task automatic test_pause_drain();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      repeat (50) send_pixel(random_pixel());
      release_request();
      wait_drained();
      repeat (50) send_pixel(random_pixel());
      release_request();
   endtask

   // Output ready: random stalls, or a long counted hold when requested
   initial begin
      int unsigned stall_left;
      int unsigned held;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_request) begin
            rsp_if.ready <= 1'b0;
            held = 0;
            while (held < LONG_HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
            hold_request = 1'b0;
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = rsp_gaps_on ? gap_cycles() : 0;
            if (stall_left > 0) begin
               rsp_if.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   // Check each response against the oldest expected result
   always @(posedge clock) begin
      pending_hsv_type exp_px;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         pixels_checked++;
         if (pending_hsv.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response with none outstanding: hue=%0d sat=%0d val=%0d",
                        $realtime, rsp_if.hue, rsp_if.saturation, rsp_if.value);
         end else begin
            exp_px = pending_hsv.pop_front();
            if (rsp_if.hue !== exp_px.hsv.hue || rsp_if.saturation !== exp_px.hsv.saturation ||
                rsp_if.value !== exp_px.hsv.value) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"%0t: rgb=(%0d,%0d,%0d) expected hue=%0d sat=%0d val=%0d,",
                            " got hue=%0d sat=%0d val=%0d"},
                           $realtime, exp_px.pixel.red, exp_px.pixel.green, exp_px.pixel.blue,
                           exp_px.hsv.hue, exp_px.hsv.saturation, exp_px.hsv.value,
                           rsp_if.hue, rsp_if.saturation, rsp_if.value);
            end
         end
      end
   end

   // End the run if nothing moves on either channel for too long
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, pending_hsv.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.red   <= '0;
      req_if.green <= '0;
      req_if.blue  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_stream();
      test_random_gaps();
      test_output_hold();
      test_pause_drain();

      // settle: every result back, then watch for strays
      wait_drained();
      repeat (DRAIN_SLACK) @(posedge clock);
      if (pending_hsv.size() != 0) mismatch_count++;

      $display("Converted %0d pixels, checked %0d results, %0d mismatches", pixels_sent,
               pixels_checked, mismatch_count);
      $display("Covered black, grey, tied maxima, half rounding, random gaps and a long output hold");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/rhc_pkg.sv
rtl/core/rhc_req_if.sv
rtl/core/rhc_rsp_if.sv
rtl/core/rhc_front.sv
rtl/core/rhc_div_cell.sv
rtl/core/rgb_to_hsv_convert_top.sv
dv/rgb_to_hsv_convert_top_tb.sv
